[rtl/core/lpc_pkg.sv]
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared constants, command codes and controller/datapath types for the
// LPC synthesis/analysis filter core.
// ----------------------------------------------------------------------------
package lpc_pkg;

    // Default sizing
    localparam int MAX_ORDER    = 16;
    localparam int SAMPLE_WIDTH = 16;

    // Fixed field widths
    localparam int CMD_W      = 2;
    localparam int COEF_W     = 16;
    localparam int INDEX_W    = 5;
    localparam int ORDER_W    = 5;
    localparam int SHIFT_W    = 4;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 2;
    // Order and tap compares, wide enough for the order field and MAX_ORDER up to 32
    localparam int CMP_W      = ORDER_W + 1;

    // Input commands
    localparam logic [CMD_W-1:0] CMD_FILTER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT = 2'd2;

    // Configuration reset values
    localparam logic [ORDER_W-1:0] ORDER_RST = 5'd10;
    localparam logic               MODE_RST  = 1'b0;
    localparam logic [SHIFT_W-1:0] SHIFT_RST = 4'd12;

    // Filter modes
    localparam logic MODE_SYNTH = 1'b0;

    // Controller to datapath commands
    typedef struct packed {
        logic start;       // capture sample, seed accumulator, reset tap counter
        logic mac_en;      // multiply current tap, advance counter
        logic commit;      // round, saturate, write result, shift history
        logic load_coef;   // write one coefficient
        logic clear_hist;  // zero the history line
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic ord_zero;    // effective order is zero
        logic last_tap;    // counter sits on the final tap
        logic out_free;    // result register can take a new beat
    } t_dp_stat;

endpackage

[rtl/core/lpc_in_if.sv]
// ----------------------------------------------------------------------------
// lpc_in_if
// Input stream channel: command, sample and coefficient load payload.
// ----------------------------------------------------------------------------
interface lpc_in_if #(
    parameter int SAMPLE_WIDTH = lpc_pkg::SAMPLE_WIDTH
) ();
    logic                               valid;
    logic                               ready;
    logic [lpc_pkg::CMD_W-1:0]          cmd;
    logic signed [SAMPLE_WIDTH-1:0]     sample_in;
    logic [lpc_pkg::INDEX_W-1:0]        coef_index;
    logic signed [lpc_pkg::COEF_W-1:0]  coef_value;

    modport source (output valid, output cmd, output sample_in, output coef_index,
                    output coef_value, input ready);
    modport sink   (input valid, input cmd, input sample_in, input coef_index,
                    input coef_value, output ready);
endinterface

[rtl/core/lpc_out_if.sv]
// ----------------------------------------------------------------------------
// lpc_out_if
// Output stream channel: filtered sample and saturation flag.
// ----------------------------------------------------------------------------
interface lpc_out_if #(
    parameter int SAMPLE_WIDTH = lpc_pkg::SAMPLE_WIDTH
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           saturated;

    modport source (output valid, output sample_out, output saturated, input ready);
    modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

[rtl/core/lpc_ctrl.sv]
// ----------------------------------------------------------------------------
// lpc_ctrl
// Sequencer: accepts input beats, steps the shared MAC over the taps and
// commits each filtered sample once the result register is free.
// ----------------------------------------------------------------------------
module lpc_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [lpc_pkg::CMD_W-1:0] i_cmd,
    output logic                      o_ready,
    input  lpc_pkg::t_dp_stat         i_stat,
    output lpc_pkg::t_dp_cmd          o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MAC   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_ROUND = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        lpc_pkg::CMD_FILTER: begin
                            o_cmd.start = 1'b1;
                            n_state     = i_stat.ord_zero ? ST_ROUND : ST_MAC;
                        end
                        lpc_pkg::CMD_LOAD:  o_cmd.load_coef  = 1'b1;
                        lpc_pkg::CMD_CLEAR: o_cmd.clear_hist = 1'b1;
                        default:            ;
                    endcase
                end
            end
            ST_MAC: begin
                o_cmd.mac_en = 1'b1;
                if (i_stat.last_tap) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    a_drain_to_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |=> (r_state == ST_ROUND))
        else $error("drain not followed by rounding");
    a_commit_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_ready)
        else $error("not idle after commit");
    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> !o_ready)
        else $error("filter beat did not start the tap loop");
`endif

endmodule

[rtl/core/lpc_dpath.sv]
// ----------------------------------------------------------------------------
// lpc_dpath
// Datapath: configuration, coefficient table, history line, shared
// multiply-accumulate, rounding/saturation and the result register.
// ----------------------------------------------------------------------------
module lpc_dpath #(
    parameter int MAX_ORDER    = lpc_pkg::MAX_ORDER,
    parameter int SAMPLE_WIDTH = lpc_pkg::SAMPLE_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [lpc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lpc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input payload
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample_in,
    input  logic [lpc_pkg::INDEX_W-1:0]         i_coef_index,
    input  logic signed [lpc_pkg::COEF_W-1:0]   i_coef_value,
    // output channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      o_sample_out,
    output logic                                o_saturated,
    // control
    input  lpc_pkg::t_dp_cmd                    i_cmd,
    output lpc_pkg::t_dp_stat                   o_stat
);

    localparam int IDX_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int PROD_W = lpc_pkg::COEF_W + SAMPLE_WIDTH;
    localparam int ACC_W  = SAMPLE_WIDTH + lpc_pkg::COEF_W + $clog2(MAX_ORDER + 1) + 1;
    localparam int CMP_W  = lpc_pkg::CMP_W;

    localparam logic signed [ACC_W-1:0] HI_EXT =
        {{(ACC_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] LO_EXT = ~HI_EXT;

    // Configuration registers
    logic [lpc_pkg::ORDER_W-1:0]       r_order;
    logic                              r_mode;
    logic [lpc_pkg::SHIFT_W-1:0]       r_shift;

    // Stores
    logic signed [lpc_pkg::COEF_W-1:0] r_coef [MAX_ORDER];
    logic signed [SAMPLE_WIDTH-1:0]    r_hist [MAX_ORDER];

    // MAC pipeline
    logic signed [SAMPLE_WIDTH-1:0]    r_x;
    logic [IDX_W-1:0]                  r_cnt;
    logic signed [PROD_W-1:0]          r_prod;
    logic                              r_prod_vld;
    logic signed [ACC_W-1:0]           r_acc;

    // Result register
    logic                              r_out_vld;
    logic signed [SAMPLE_WIDTH-1:0]    r_out_y;
    logic                              r_out_sat;

    logic [CMP_W-1:0]                  ord_clip;
    logic [CMP_W-1:0]                  load_j;
    logic                              load_ok;
    logic [IDX_W-1:0]                  load_idx;
    logic signed [ACC_W-1:0]           x_seed;
    logic signed [ACC_W-1:0]           prod_ext;
    logic signed [ACC_W-1:0]           rnd;
    logic signed [ACC_W-1:0]           acc_rnd;
    logic signed [ACC_W-1:0]           y_full;
    logic signed [SAMPLE_WIDTH-1:0]    y_sat;
    logic                              sat;

    // Effective order, clipped to the table depth
    always_comb begin
        if ({1'b0, r_order} > CMP_W'(MAX_ORDER)) begin
            ord_clip = CMP_W'(MAX_ORDER);
        end else begin
            ord_clip = {1'b0, r_order};
        end
    end

    assign o_stat.ord_zero = (ord_clip == '0);
    assign o_stat.last_tap = (CMP_W'(r_cnt) == (ord_clip - CMP_W'(1)));
    assign o_stat.out_free = !r_out_vld || i_ready;

    // Coefficient load address: taps 1..MAX_ORDER map to entries 0..MAX_ORDER-1
    assign load_j   = {1'b0, i_coef_index};
    assign load_ok  = (i_coef_index != '0) && (load_j <= CMP_W'(MAX_ORDER));
    assign load_idx = IDX_W'(load_j - CMP_W'(1));

    // Accumulator seed and product extension
    assign x_seed   = ACC_W'(i_sample_in) <<< r_shift;
    assign prod_ext = ACC_W'(r_prod);

    // Round half up, floor shift, saturate
    always_comb begin
        if (r_shift == '0) begin
            rnd = '0;
        end else begin
            rnd = ACC_W'(1) <<< (r_shift - lpc_pkg::SHIFT_W'(1));
        end
        acc_rnd = r_acc + rnd;
        y_full  = acc_rnd >>> r_shift;
        if (y_full > HI_EXT) begin
            y_sat = SAMPLE_WIDTH'(HI_EXT);
            sat   = 1'b1;
        end else if (y_full < LO_EXT) begin
            y_sat = SAMPLE_WIDTH'(LO_EXT);
            sat   = 1'b1;
        end else begin
            y_sat = SAMPLE_WIDTH'(y_full);
            sat   = 1'b0;
        end
    end

    // Configuration, stores and control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order    <= lpc_pkg::ORDER_RST;
            r_mode     <= lpc_pkg::MODE_RST;
            r_shift    <= lpc_pkg::SHIFT_RST;
            r_prod_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            for (int k = 0; k < MAX_ORDER; k++) begin
                r_coef[k] <= '0;
                r_hist[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lpc_pkg::REG_ORDER: r_order <= i_cfg_data[lpc_pkg::ORDER_W-1:0];
                    lpc_pkg::REG_MODE:  r_mode  <= i_cfg_data[0];
                    lpc_pkg::REG_SHIFT: r_shift <= i_cfg_data[lpc_pkg::SHIFT_W-1:0];
                    default:            ;
                endcase
            end
            r_prod_vld <= i_cmd.mac_en;
            if (i_cmd.load_coef && load_ok) begin
                r_coef[load_idx] <= i_coef_value;
            end
            // shift the whole line on commit, zero it on clear
            if (i_cmd.clear_hist) begin
                for (int k = 0; k < MAX_ORDER; k++) begin
                    r_hist[k] <= '0;
                end
            end else if (i_cmd.commit) begin
                for (int k = MAX_ORDER - 1; k > 0; k--) begin
                    r_hist[k] <= r_hist[k-1];
                end
                r_hist[0] <= (r_mode == lpc_pkg::MODE_SYNTH) ? y_sat : r_x;
            end
            if (i_cmd.commit) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // MAC pipeline and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x   <= i_sample_in;
            r_cnt <= '0;
            r_acc <= x_seed;
        end else begin
            if (i_cmd.mac_en) begin
                r_cnt <= r_cnt + IDX_W'(1);
            end
            if (r_prod_vld) begin
                r_acc <= (r_mode == lpc_pkg::MODE_SYNTH) ? r_acc - prod_ext
                                                         : r_acc + prod_ext;
            end
        end
        r_prod <= r_coef[r_cnt] * r_hist[r_cnt];
        if (i_cmd.commit) begin
            r_out_y   <= y_sat;
            r_out_sat <= sat;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_sample_out = r_out_y;
    assign o_saturated  = r_out_sat;

`ifndef NO_ASSERTIONS
    a_commit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_vld || i_ready))
        else $error("result overwritten while stalled");
    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_vld)
        else $error("committed result not presented");
    a_no_product_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.start && r_prod_vld))
        else $error("product pending when a new sample starts");
`endif

endmodule

[rtl/core/lpc_synthesis_analysis_filter_core.sv]
// ----------------------------------------------------------------------------
// lpc_synthesis_analysis_filter_core
// LPC filter of adjustable order: all-pole synthesis or all-zero residue
// analysis, with coefficient loading and history clear through input beats.
// ----------------------------------------------------------------------------
// A filter beat steps the tap loop, then a drain state and a rounding state;
//   its result is registered on commit (order zero skips the loop and drain);
//   orders above MAX_ORDER run as MAX_ORDER. No new beat is taken before the
//   last result is committed; the single shared multiplier steps one tap per
//   cycle; a stalled output holds the rounding state; load/clear finish in idle.
// Reset (synchronous, active low) zeroes coefficients and history at once and
//   sets order 10, synthesis mode, shift 12.
module lpc_synthesis_analysis_filter_core #(
    parameter int MAX_ORDER    = lpc_pkg::MAX_ORDER,
    parameter int SAMPLE_WIDTH = lpc_pkg::SAMPLE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lpc_in_if.sink                         i_in,
    lpc_out_if.source                      o_out
);

    lpc_pkg::t_dp_cmd  dp_cmd;
    lpc_pkg::t_dp_stat dp_stat;

    // Sequencer
    lpc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_cmd   (i_in.cmd),
        .o_ready (i_in.ready),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // Datapath
    lpc_dpath #(
        .MAX_ORDER    (MAX_ORDER),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_in.sample_in),
        .i_coef_index (i_in.coef_index),
        .i_coef_value (i_in.coef_value),
        .o_valid      (o_out.valid),
        .i_ready      (o_out.ready),
        .o_sample_out (o_out.sample_out),
        .o_saturated  (o_out.saturated),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat)
    );

endmodule
